// ===== rtl/ising_metropolis_spin_update_macros.svh =====
// assertion helpers for the checker file
`ifndef ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH

// property checked only outside reset
`define IMS_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define IMS_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ims_pkg.sv =====
package ims_pkg;

    localparam int GRID_SIDE  = 32;
    localparam int CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int RC_W       = 5;
    localparam int DRAW_W     = 16;
    localparam int TH_W       = 16;
    localparam int COST_W     = 5;
    localparam int NB_W       = 4;
    localparam int MAG_W      = 12;
    localparam int EN_W       = 14;
    localparam int SITE_COUNT = 5;
    localparam int STEP_W     = $clog2(SITE_COUNT + 1);
    localparam int APB_W      = 32;
    localparam int PADDR_W    = 3;

    localparam logic signed [MAG_W-1:0]  MAG_RESET  = MAG_W'(CELLS);
    localparam logic signed [EN_W-1:0]   EN_RESET   = EN_W'(-4 * CELLS);
    localparam logic signed [MAG_W-1:0]  MAG_PLUS2  = MAG_W'(2);
    localparam logic signed [MAG_W-1:0]  MAG_MINUS2 = MAG_W'(-2);
    localparam logic signed [COST_W-1:0] COST_ZERO  = COST_W'(0);
    localparam logic signed [COST_W-1:0] COST_MID   = COST_W'(4);
    localparam logic signed [COST_W-1:0] COST_HIGH  = COST_W'(8);
    localparam logic signed [NB_W-1:0]   NB_ONE     = NB_W'(1);

    // register index, taken from paddr bit 2
    localparam logic REG_TH4 = 1'b0;
    localparam logic REG_TH8 = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_DECIDE
    } t_state;

    typedef enum logic [2:0] {
        SITE_SELF,
        SITE_UP,
        SITE_DOWN,
        SITE_RIGHT,
        SITE_LEFT
    } t_site;

    typedef enum logic {
        ACT_FLIP = 1'b0,
        ACT_LOAD = 1'b1
    } t_action;

    typedef struct packed {
        logic              capture;
        logic              clear;
        logic [ADDR_W-1:0] clr_addr;
        logic              rd_en;
        t_site             rd_site;
        logic              dat_en;
        t_site             dat_site;
        logic              decide;
    } t_ctrl;

    typedef struct packed {
        logic in_grid;
        logic out_free;
    } t_stat;

    function automatic logic [RC_W-1:0] wrap_up(input logic [RC_W-1:0] a);
        if (int'(a) + 1 >= GRID_SIDE) begin
            return '0;
        end
        return a + RC_W'(1);
    endfunction

    function automatic logic [RC_W-1:0] wrap_down(input logic [RC_W-1:0] a);
        if (a == '0) begin
            return RC_W'(GRID_SIDE - 1);
        end
        return a - RC_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] site_addr(input logic [RC_W-1:0] r,
                                                    input logic [RC_W-1:0] c);
        return ADDR_W'(int'(r) * GRID_SIDE + int'(c));
    endfunction

endpackage

// ===== rtl/ims_ram.sv =====
module ims_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ims_ctrl.sv =====
module ims_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ims_pkg::t_stat i_stat,
    output logic           o_ready,
    output ims_pkg::t_ctrl o_ctrl
);

    ims_pkg::t_state                r_state, n_state;
    logic [ims_pkg::STEP_W-1:0]     r_step, n_step;
    logic [ims_pkg::ADDR_W-1:0]     r_clr, n_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ims_pkg::ST_CLEAR;
            r_step  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_clr   = r_clr;
        o_ready = 1'b0;
        o_ctrl  = '0;
        unique case (r_state)
            ims_pkg::ST_CLEAR: begin
                // set every spin to +1 after reset
                o_ctrl.clear    = 1'b1;
                o_ctrl.clr_addr = r_clr;
                n_clr           = r_clr + ims_pkg::ADDR_W'(1);
                if (r_clr == ims_pkg::ADDR_W'(ims_pkg::CELLS - 1)) begin
                    n_state = ims_pkg::ST_IDLE;
                end
            end
            ims_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_step         = '0;
                    n_state        = ims_pkg::ST_FETCH;
                end
            end
            ims_pkg::ST_FETCH: begin
                if (!i_stat.in_grid) begin
                    n_state = ims_pkg::ST_DECIDE;
                end else begin
                    // read site k while the data of site k-1 comes back
                    if (r_step < ims_pkg::STEP_W'(ims_pkg::SITE_COUNT)) begin
                        o_ctrl.rd_en   = 1'b1;
                        o_ctrl.rd_site = ims_pkg::t_site'(r_step);
                    end
                    if (r_step != '0) begin
                        o_ctrl.dat_en   = 1'b1;
                        o_ctrl.dat_site = ims_pkg::t_site'(r_step - ims_pkg::STEP_W'(1));
                    end
                    if (r_step == ims_pkg::STEP_W'(ims_pkg::SITE_COUNT)) begin
                        n_state = ims_pkg::ST_DECIDE;
                    end
                    n_step = r_step + ims_pkg::STEP_W'(1);
                end
            end
            ims_pkg::ST_DECIDE: begin
                if (i_stat.out_free) begin
                    o_ctrl.decide = 1'b1;
                    n_state       = ims_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ims_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/ims_dp.sv =====
module ims_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ims_pkg::t_ctrl                     i_ctrl,
    input  ims_pkg::t_action                   i_action,
    input  logic [ims_pkg::RC_W-1:0]           i_row,
    input  logic [ims_pkg::RC_W-1:0]           i_col,
    input  logic                               i_load_spin,
    input  logic [ims_pkg::DRAW_W-1:0]         i_random_draw,
    input  logic [ims_pkg::TH_W-1:0]           i_th4,
    input  logic [ims_pkg::TH_W-1:0]           i_th8,
    output ims_pkg::t_stat                     o_stat,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_flipped,
    output logic                               o_spin_after,
    output logic signed [ims_pkg::COST_W-1:0]  o_flip_cost,
    output logic signed [ims_pkg::MAG_W-1:0]   o_magnetization,
    output logic signed [ims_pkg::EN_W-1:0]    o_total_energy
);

    // captured item
    ims_pkg::t_action                 r_action;
    logic [ims_pkg::RC_W-1:0]         r_row;
    logic [ims_pkg::RC_W-1:0]         r_col;
    logic                             r_ld;
    logic [ims_pkg::DRAW_W-1:0]       r_draw;
    logic                             r_in_grid;

    // gathered neighbourhood
    logic                             r_s;
    logic signed [ims_pkg::NB_W-1:0]  r_nsum;

    // running totals
    logic signed [ims_pkg::MAG_W-1:0] r_mag;
    logic signed [ims_pkg::EN_W-1:0]  r_en;

    // result register
    logic                              r_out_valid;
    logic                              r_o_flipped;
    logic                              r_o_after;
    logic signed [ims_pkg::COST_W-1:0] r_o_cost;
    logic signed [ims_pkg::MAG_W-1:0]  r_o_mag;
    logic signed [ims_pkg::EN_W-1:0]   r_o_en;

    logic [ims_pkg::ADDR_W-1:0]        self_addr;
    logic [ims_pkg::ADDR_W-1:0]        rd_addr;
    logic [ims_pkg::ADDR_W-1:0]        wr_addr;
    logic                              ram_we;
    logic [0:0]                        ram_wdata;
    logic [0:0]                        ram_rdata;

    logic signed [ims_pkg::COST_W-1:0] ns_x2;
    logic signed [ims_pkg::COST_W-1:0] cost;
    logic                              change_flip;
    logic                              change;
    logic                              new_spin;
    logic signed [ims_pkg::MAG_W-1:0]  n_mag;
    logic signed [ims_pkg::EN_W-1:0]   n_en;

    assign self_addr = ims_pkg::site_addr(r_row, r_col);

    always_comb begin
        unique case (i_ctrl.rd_site)
            ims_pkg::SITE_SELF:  rd_addr = self_addr;
            ims_pkg::SITE_UP:    rd_addr = ims_pkg::site_addr(ims_pkg::wrap_up(r_row), r_col);
            ims_pkg::SITE_DOWN:  rd_addr = ims_pkg::site_addr(ims_pkg::wrap_down(r_row), r_col);
            ims_pkg::SITE_RIGHT: rd_addr = ims_pkg::site_addr(r_row, ims_pkg::wrap_up(r_col));
            ims_pkg::SITE_LEFT:  rd_addr = ims_pkg::site_addr(r_row, ims_pkg::wrap_down(r_col));
            default:             rd_addr = self_addr;
        endcase
    end

    // flip decision from the gathered spins
    always_comb begin
        ns_x2 = ims_pkg::COST_W'(r_nsum) <<< 1;
        if (!r_in_grid) begin
            cost = ims_pkg::COST_ZERO;
        end else begin
            cost = r_s ? ns_x2 : -ns_x2;
        end
        change_flip = (cost <= ims_pkg::COST_ZERO)
                   || ((cost == ims_pkg::COST_MID)  && (i_th4 > r_draw))
                   || ((cost == ims_pkg::COST_HIGH) && (i_th8 > r_draw));
        if (r_action == ims_pkg::ACT_LOAD) begin
            change = r_in_grid && (r_ld != r_s);
        end else begin
            change = r_in_grid && change_flip;
        end
        new_spin = r_s ^ change;
        n_mag    = r_mag + (r_s ? ims_pkg::MAG_MINUS2 : ims_pkg::MAG_PLUS2);
        n_en     = r_en + (ims_pkg::EN_W'(cost) <<< 1);
    end

    assign ram_we    = i_ctrl.clear || (i_ctrl.decide && change);
    assign wr_addr   = i_ctrl.clear ? i_ctrl.clr_addr : self_addr;
    assign ram_wdata = i_ctrl.clear ? 1'b1 : new_spin;

    ims_ram #(
        .WIDTH (1),
        .DEPTH (ims_pkg::CELLS)
    ) u_spins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctrl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_action  <= i_action;
            r_row     <= i_row;
            r_col     <= i_col;
            r_ld      <= i_load_spin;
            r_draw    <= i_random_draw;
            r_in_grid <= (int'(i_row) < ims_pkg::GRID_SIDE)
                      && (int'(i_col) < ims_pkg::GRID_SIDE);
        end
        if (i_ctrl.capture) begin
            r_nsum <= '0;
        end else if (i_ctrl.dat_en) begin
            if (i_ctrl.dat_site == ims_pkg::SITE_SELF) begin
                r_s <= ram_rdata[0];
            end else begin
                r_nsum <= ram_rdata[0] ? r_nsum + ims_pkg::NB_ONE : r_nsum - ims_pkg::NB_ONE;
            end
        end
        if (i_ctrl.decide) begin
            r_o_flipped <= change;
            r_o_after   <= r_in_grid && new_spin;
            r_o_cost    <= cost;
            r_o_mag     <= change ? n_mag : r_mag;
            r_o_en      <= change ? n_en : r_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= ims_pkg::MAG_RESET;
            r_en        <= ims_pkg::EN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.decide && change) begin
                r_mag <= n_mag;
                r_en  <= n_en;
            end
            if (i_ctrl.decide) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_grid  = r_in_grid;
    assign o_stat.out_free = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_flipped       = r_o_flipped;
    assign o_spin_after    = r_o_after;
    assign o_flip_cost     = r_o_cost;
    assign o_magnetization = r_o_mag;
    assign o_total_energy  = r_o_en;

endmodule

// ===== rtl/ising_metropolis_spin_update.sv =====
// Metropolis spin update on a periodic square grid of +1/-1 spins.
// Input stream (s_*): one word per flip attempt or spin load, the action in
// s_tuser, site and random draw in s_tdata. Output stream (m_*): one word per
// input word with flip flag, new spin, flip cost and the running totals.
// APB port: the two Boltzmann thresholds at byte addresses 0 and 4.
// Sequence: an in-grid word is accepted in the idle step, gathers its sites
// in the fetch step and is settled in the decide step, which loads the result
// register; then the next word can be accepted. The five site reads share the
// single read port of the spin memory, one per cycle. A site outside the
// grid reads no site and goes from the fetch step straight to decide.
// The result register frees the input side: a new word is taken while a
// result waits; the block holds in the decide step only while the previous
// result is still stalled by the receiver.
// Reset: a clearing pass writes +1 into every site, s_tready stays low
// meanwhile; register writes are taken during the pass.
module ising_metropolis_spin_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // row[4:0] col[9:5] load_spin[10] random_draw[26:11]
    input  logic [0:0]                  s_tuser,   // action[0]
    // master side
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // flipped[0] spin_after[1] flip_cost[6:2]
                                                   // magnetization[18:7] total_energy[32:19]
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ims_pkg::PADDR_W-1:0] paddr,
    input  logic [ims_pkg::APB_W-1:0]   pwdata,
    output logic [ims_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);

    logic [ims_pkg::TH_W-1:0]          r_th4;
    logic [ims_pkg::TH_W-1:0]          r_th8;

    ims_pkg::t_ctrl                    ctrl;
    ims_pkg::t_stat                    stat;
    logic                              flipped;
    logic                              spin_after;
    logic signed [ims_pkg::COST_W-1:0] flip_cost;
    logic signed [ims_pkg::MAG_W-1:0]  magnetization;
    logic signed [ims_pkg::EN_W-1:0]   total_energy;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th4 <= '0;
            r_th8 <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ims_pkg::REG_TH4: r_th4 <= pwdata[ims_pkg::TH_W-1:0];
                ims_pkg::REG_TH8: r_th8 <= pwdata[ims_pkg::TH_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ims_pkg::REG_TH4: prdata = ims_pkg::APB_W'(r_th4);
            ims_pkg::REG_TH8: prdata = ims_pkg::APB_W'(r_th8);
        endcase
    end

    ims_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_stat  (stat),
        .o_ready (s_tready),
        .o_ctrl  (ctrl)
    );

    ims_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_action        (ims_pkg::t_action'(s_tuser[0])),
        .i_row           (s_tdata[4:0]),
        .i_col           (s_tdata[9:5]),
        .i_load_spin     (s_tdata[10]),
        .i_random_draw   (s_tdata[26:11]),
        .i_th4           (r_th4),
        .i_th8           (r_th8),
        .o_stat          (stat),
        .o_valid         (m_tvalid),
        .i_ready         (m_tready),
        .o_flipped       (flipped),
        .o_spin_after    (spin_after),
        .o_flip_cost     (flip_cost),
        .o_magnetization (magnetization),
        .o_total_energy  (total_energy)
    );

    assign m_tdata = {7'b0, total_energy, magnetization, flip_cost, spin_after, flipped};

endmodule

// ===== rtl/ims_chk.sv =====
`include "ising_metropolis_spin_update_macros.svh"

module ims_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a taken word keeps the input side closed for its fetch
    `IMS_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, (s_tvalid && s_tready) |=> !s_tready, "input taken while a word is in progress")

    // stalled result holds
    `IMS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed or dropped")

    // the flip cost is always twice a neighbour sum
    `IMS_ASSERT_RST(a_cost_even, i_clk, i_rst_n, m_tvalid |-> !m_tdata[2], "odd flip cost reported")

    // reset empties the output and starts the clearing pass
    `IMS_ASSERT(a_reset_quiet, i_clk, !i_rst_n |=> (!m_tvalid && !s_tready), "block active straight after reset")

endmodule

bind ising_metropolis_spin_update ims_chk u_ims_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/ims_tb_pkg.sv =====
`timescale 1ns / 1ps

package ims_tb_pkg;

    import ims_pkg::*;

    typedef struct packed {
        logic                      flipped;
        logic                      spin_after;
        logic signed [COST_W-1:0]  cost;
        logic signed [MAG_W-1:0]   mag;
        logic signed [EN_W-1:0]    energy;
    } t_update;

    class metropolis_tracker;

        bit             spins [CELLS];
        int             mag_sum;
        int             energy_sum;
        logic [TH_W-1:0] th4;
        logic [TH_W-1:0] th8;
        t_update        expected_updates [$];
        int             errors;

        function new();
            foreach (spins[i]) begin
                spins[i] = 1'b1;
            end
            mag_sum    = CELLS;
            energy_sum = -4 * CELLS;
            th4        = '0;
            th8        = '0;
            errors     = 0;
        endfunction

        function void set_threshold(logic idx, logic [TH_W-1:0] val);
            if (idx == REG_TH4) begin
                th4 = val;
            end else begin
                th8 = val;
            end
        endfunction

        function int spin_at(int r, int c);
            return spins[r * GRID_SIDE + c] ? 1 : -1;
        endfunction

        function int pending();
            return expected_updates.size();
        endfunction

        function void take_input(t_action act, int r, int c, bit ld, logic [DRAW_W-1:0] draw);
            int      s;
            int      nb;
            int      cost;
            bit      change;
            t_update u;
            u = '0;
            if (r < GRID_SIDE && c < GRID_SIDE) begin
                s  = spin_at(r, c);
                // periodic wraparound on both axes
                nb = spin_at((r + 1) % GRID_SIDE, c)
                   + spin_at((r + GRID_SIDE - 1) % GRID_SIDE, c)
                   + spin_at(r, (c + 1) % GRID_SIDE)
                   + spin_at(r, (c + GRID_SIDE - 1) % GRID_SIDE);
                cost = 2 * s * nb;
                if (act == ACT_FLIP) begin
                    change = (cost <= 0)
                          || (cost == 4 && th4 > draw)
                          || (cost == 8 && th8 > draw);
                end else begin
                    change = ((ld ? 1 : -1) != s);
                end
                if (change) begin
                    spins[r * GRID_SIDE + c] = (s < 0);
                    mag_sum    -= 2 * s;
                    energy_sum += 2 * cost;
                    u.flipped   = 1'b1;
                end
                u.spin_after = spins[r * GRID_SIDE + c];
                u.cost       = COST_W'(cost);
            end
            u.mag    = MAG_W'(mag_sum);
            u.energy = EN_W'(energy_sum);
            expected_updates.push_back(u);
        endfunction

        function void check_result(logic [39:0] word);
            t_update want;
            t_update got;
            if (expected_updates.size() == 0) begin
                $error("result word with no update pending: %h", word);
                errors++;
                return;
            end
            want           = expected_updates.pop_front();
            got.flipped    = word[0];
            got.spin_after = word[1];
            got.cost       = word[6:2];
            got.mag        = word[18:7];
            got.energy     = word[32:19];
            if (got.flipped !== want.flipped) begin
                $error("flipped: expected %0d, got %0d", want.flipped, got.flipped);
                errors++;
            end
            if (got.spin_after !== want.spin_after) begin
                $error("spin_after: expected %0d, got %0d", want.spin_after, got.spin_after);
                errors++;
            end
            if (got.cost !== want.cost) begin
                $error("flip_cost: expected %0d, got %0d", want.cost, got.cost);
                errors++;
            end
            if (got.mag !== want.mag) begin
                $error("magnetization: expected %0d, got %0d", want.mag, got.mag);
                errors++;
            end
            if (got.energy !== want.energy) begin
                $error("total_energy: expected %0d, got %0d", want.energy, got.energy);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import ims_pkg::*;
    import ims_tb_pkg::*;

    localparam int RUN_LIMIT        = 1_000_000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int SINK_HOLD_CYCLES = 300;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    // set by the sender to ask the sink for a long hold-off
    bit                  sink_hold = 1'b0;
    int                  cycle_count = 0;

    metropolis_tracker   tracker = new();

    ising_metropolis_spin_update uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(t_action act, logic [RC_W-1:0] r, logic [RC_W-1:0] c,
                             logic ld, logic [DRAW_W-1:0] draw, int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        // row[4:0] col[9:5] load_spin[10] random_draw[26:11]
        s_tdata  <= {5'b0, draw, ld, c, r};
        do @(posedge i_clk); while (!s_tready);
        tracker.take_input(act, int'(r), int'(c), ld, draw);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [TH_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_W-TH_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_threshold(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_thresholds(logic [TH_W-1:0] t4, logic [TH_W-1:0] t8);
        wait_idle();
        write_reg(REG_TH4, t4);
        write_reg(REG_TH8, t8);
    endtask

    task automatic run_phase(int n_items, int load_pct, bit with_pressure);
        t_action          act;
        logic [RC_W-1:0]  r;
        logic [RC_W-1:0]  c;
        int               x;
        bit               burst;
        int               burst_left;
        burst      = 1'b0;
        burst_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
                burst      = ($urandom_range(0, 5) == 0);
                burst_left = $urandom_range(20, 60);
            end
            burst_left--;
            if (with_pressure && i == n_items / 3) begin
                sink_hold = 1'b1;
            end
            if (with_pressure && i == (2 * n_items) / 3) begin
                // hold the source until every update is back
                s_tvalid <= 1'b0;
                do @(posedge i_clk); while (tracker.pending() != 0);
            end
            act = ($urandom_range(0, 99) < load_pct) ? ACT_LOAD : ACT_FLIP;
            // half the sites sit around the wrap corner so updates interact
            if ($urandom_range(0, 1)) begin
                x = $urandom_range(0, 3);
                r = RC_W'((x < 2) ? x : x + GRID_SIDE - 4);
                x = $urandom_range(0, 3);
                c = RC_W'((x < 2) ? x : x + GRID_SIDE - 4);
            end else begin
                r = RC_W'($urandom_range(0, GRID_SIDE - 1));
                c = RC_W'($urandom_range(0, GRID_SIDE - 1));
            end
            send_item(act, r, c, 1'($urandom_range(0, 1)),
                      DRAW_W'($urandom_range(0, 65535)), pick_gap(burst));
        end
    endtask

    // sink side
    initial begin
        int stall_left;
        int free_left;
        int hold_left;
        int r;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                tracker.check_result(m_tdata);
            end
            if (sink_hold) begin
                sink_hold = 1'b0;
                hold_left = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (stall_left == 0 && free_left == 0) begin
                    r = $urandom_range(0, 9);
                    if (r < 6) begin
                        free_left = $urandom_range(1, 8);
                    end else if (r < 9) begin
                        stall_left = $urandom_range(1, 3);
                    end else if ($urandom_range(0, 1)) begin
                        stall_left = $urandom_range(15, 40);
                    end else begin
                        free_left = $urandom_range(40, 120);
                    end
                end
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    free_left--;
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-up grid, thresholds at reset: cost 8 refused, same-value load
        send_item(ACT_FLIP, 0, 0, 1'b1, 16'h0000, pick_gap(0));
        send_item(ACT_LOAD, 0, 0, 1'b1, 16'hffff, pick_gap(0));
        send_item(ACT_LOAD, 0, 0, 1'b0, 16'h1234, pick_gap(0));
        // lone down spin, cost -8
        send_item(ACT_FLIP, 0, 0, 1'b1, 16'hffff, pick_gap(0));
        send_item(ACT_LOAD, 0, 1, 1'b0, 16'h0000, pick_gap(0));
        send_item(ACT_LOAD, 1, 0, 1'b0, 16'h0000, pick_gap(0));
        // balanced neighbours, cost 0 both ways
        send_item(ACT_FLIP, 0, 0, 1'b0, 16'hffff, pick_gap(0));
        send_item(ACT_FLIP, 0, 0, 1'b1, 16'h0000, pick_gap(0));
        send_item(ACT_LOAD, 31, 31, 1'b0, 16'h0000, pick_gap(0));
        send_item(ACT_FLIP, 31, 31, 1'b0, 16'hffff, pick_gap(0));
        // cost 4 refused with zero threshold
        send_item(ACT_LOAD, 4, 5, 1'b0, 16'hffff, pick_gap(0));
        send_item(ACT_FLIP, 5, 5, 1'b0, 16'h0000, pick_gap(0));
        send_item(ACT_LOAD, 31, 0, 1'b0, 16'h0000, pick_gap(0));
        send_item(ACT_LOAD, 0, 31, 1'b0, 16'h0000, pick_gap(0));

        set_thresholds(16'hffff, 16'hffff);
        // threshold equal to draw refuses, one below accepts
        send_item(ACT_FLIP, 5, 5, 1'b1, 16'hffff, pick_gap(0));
        send_item(ACT_FLIP, 5, 5, 1'b0, 16'hfffe, pick_gap(0));
        send_item(ACT_FLIP, 5, 5, 1'b0, 16'h0000, pick_gap(0));
        send_item(ACT_FLIP, 10, 10, 1'b1, 16'h0000, pick_gap(0));
        send_item(ACT_FLIP, 10, 10, 1'b0, 16'hffff, pick_gap(0));
        send_item(ACT_FLIP, 31, 0, 1'b1, 16'h8000, pick_gap(0));
        send_item(ACT_FLIP, 0, 31, 1'b0, 16'h7fff, pick_gap(0));
        send_item(ACT_LOAD, 31, 31, 1'b1, 16'h5555, pick_gap(0));

        set_thresholds(16'h0000, 16'h0000);
        run_phase(300, 60, 1'b0);
        set_thresholds(16'hffff, 16'hffff);
        run_phase(300, 40, 1'b0);
        set_thresholds(TH_W'($urandom_range(0, 65535)), TH_W'($urandom_range(0, 65535)));
        run_phase(300, 30, 1'b1);
        set_thresholds(16'd40000, 16'd8000);
        run_phase(250, 30, 1'b0);
        set_thresholds(TH_W'($urandom_range(0, 65535)), TH_W'($urandom_range(0, 65535)));
        run_phase(250, 30, 1'b0);

        wait_idle();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ims_pkg.sv
rtl/ims_ram.sv
rtl/ims_ctrl.sv
rtl/ims_dp.sv
rtl/ising_metropolis_spin_update.sv
rtl/ims_chk.sv
dv/ims_tb_pkg.sv
dv/tb_top.sv
